// File: src/alc_pkg.sv
// Shared constants, types and the power-table function for the ambient light lux block.
// Used by every module under src; has no dependencies of its own.
`default_nettype none

package alc_pkg;

    localparam int CH_W                = 16;
    localparam int LUX_W               = 27;
    localparam int BAND_W              = 3;
    localparam int ACC_W               = 48;
    localparam int ENTRY_W             = 16;
    localparam int COEF_W              = 32;
    localparam int LUX_FRAC_BITS       = 16;
    localparam int LUX_SHIFT           = COEF_W - LUX_FRAC_BITS;
    localparam int POWER_TABLE_ENTRIES = 256;

    // Quotient bits resolved per divider stage.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = CH_W / DIV_STEPS;

    localparam logic [BAND_W-1:0] BAND_ZERO = 3'd0;
    localparam logic [BAND_W-1:0] BAND_LOW  = 3'd1;
    localparam logic [BAND_W-1:0] BAND_MID  = 3'd2;
    localparam logic [BAND_W-1:0] BAND_HIGH = 3'd3;
    localparam logic [BAND_W-1:0] BAND_TOP  = 3'd4;
    localparam logic [BAND_W-1:0] BAND_OVER = 3'd5;

    // Mixing coefficients as unsigned Q0.32 words, rounded half up.
    localparam logic [COEF_W-1:0] K_B1_VIS = 32'(((64'd304 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K_B1_IR  = 32'(((64'd62 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K_B2_VIS = 32'(((64'd224 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K_B2_IR  = 32'(((64'd31 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K_B3_VIS = 32'(((64'd128 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K_B3_IR  = 32'(((64'd153 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] K_B4_VIS = 32'(((64'd146 << 32) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] K_B4_IR  = 32'(((64'd112 << 32) + 64'd50000) / 64'd100000);

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [ACC_W-1:0]  t0;
        logic [ACC_W-1:0]  kc1;
    } t_side;

    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] quo;
    } t_div;

    // Q0.16 value of r^1.4 for table entry idx, where r = idx / (2*(entries-1)).
    // Both searches set one bit at a time, so no division is needed.
    function automatic logic [ENTRY_W-1:0] pow_entry(input int unsigned idx,
                                                     input int unsigned entries);
        logic [127:0]       span;
        logic [127:0]       rhs;
        logic [127:0]       yw;
        logic [127:0]       prod;
        logic [ENTRY_W-1:0] yv;
        logic [ENTRY_W-1:0] cand;
        logic [ENTRY_W-1:0] qv;
        span = 128'(2 * (entries - 1));
        rhs  = (128'(idx) * 128'(idx)) << 80;
        yv   = '0;
        for (int b = ENTRY_W - 1; b >= 0; b--) begin
            cand = yv | (ENTRY_W'(1) << b);
            yw   = 128'(cand);
            if (yw * yw * yw * yw * yw * span * span <= rhs) begin
                yv = cand;
            end
        end
        prod = 128'(idx) * 128'(yv);
        qv   = '0;
        for (int b = ENTRY_W - 1; b >= 0; b--) begin
            cand = qv | (ENTRY_W'(1) << b);
            if (128'(cand) * span <= prod) begin
                qv = cand;
            end
        end
        return qv;
    endfunction

endpackage

`default_nettype wire

// File: src/alc_div_stage.sv
// One stage of the restoring divider that forms channel1/channel0 in Q0.16.
// Resolves DIV_STEPS quotient bits per beat; depends on alc_pkg.
`default_nettype none

module alc_div_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire alc_pkg::t_side i_side,
    input  wire alc_pkg::t_div  i_div,
    output logic               o_vld,
    output alc_pkg::t_side     o_side,
    output alc_pkg::t_div      o_div
);
    import alc_pkg::*;

    t_div   n_div;
    logic   r_vld;
    t_side  r_side;
    t_div   r_div;

    // The remainder stays below the divisor, so the doubled value fits in CH_W+1 bits.
    always_comb begin
        logic [CH_W:0] v_rem;
        n_div = i_div;
        for (int k = 0; k < DIV_STEPS; k++) begin
            v_rem = {n_div.rem, 1'b0};
            if (v_rem >= {1'b0, n_div.c0}) begin
                v_rem     = v_rem - {1'b0, n_div.c0};
                n_div.quo = {n_div.quo[CH_W-2:0], 1'b1};
            end else begin
                n_div.quo = {n_div.quo[CH_W-2:0], 1'b0};
            end
            n_div.rem = v_rem[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_div  = r_div;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_side.band == BAND_LOW) |-> (r_div.rem < r_div.c0))
        else $error("divider remainder not below channel 0");

endmodule

`default_nettype wire

// File: src/alc_pow_lut.sv
// Power table lookup: scales the ratio to a table index, then reads r^1.4.
// Two register stages; the table is built at elaboration by alc_pkg::pow_entry.
`default_nettype none

module alc_pow_lut #(
    parameter int ENTRIES = alc_pkg::POWER_TABLE_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire alc_pkg::t_side                i_side,
    input  wire logic [alc_pkg::CH_W-1:0]      i_quo,
    output logic                               o_vld,
    output alc_pkg::t_side                     o_side,
    output logic [alc_pkg::ENTRY_W-1:0]        o_entry
);
    import alc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SPAN   = 2 * (ENTRIES - 1);
    localparam int SPAN_W = $clog2(SPAN + 1);
    localparam int PROD_W = CH_W + SPAN_W;

    logic [ENTRY_W-1:0] w_tab [ENTRIES];
    logic [PROD_W-1:0]  w_scaled;
    logic [PROD_W-1:0]  w_idx_full;
    logic [IDX_W-1:0]   n_idx;

    logic               r_a_vld;
    t_side              r_a_side;
    logic [IDX_W-1:0]   r_idx;
    logic               r_b_vld;
    t_side              r_b_side;
    logic [ENTRY_W-1:0] r_entry;

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_tab
        assign w_tab[gi] = pow_entry(gi, ENTRIES);
    end

    // Index rounds down to the lower entry.
    assign w_scaled   = PROD_W'(i_quo) * PROD_W'(SPAN);
    assign w_idx_full = w_scaled >> CH_W;
    assign n_idx      = (w_idx_full > PROD_W'(ENTRIES - 1)) ? IDX_W'(ENTRIES - 1)
                                                            : w_idx_full[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_idx    <= n_idx;
            r_b_side <= r_a_side;
            r_entry  <= w_tab[r_idx];
        end
    end

    assign o_vld   = r_b_vld;
    assign o_side  = r_b_side;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: src/alc_mix.sv
// Final mix: scales the infrared term in the lowest band, subtracts, clamps and drives the output register.
// Two register stages; depends on alc_pkg.
`default_nettype none

module alc_mix (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire alc_pkg::t_side                i_side,
    input  wire logic [alc_pkg::ENTRY_W-1:0]   i_entry,
    output logic                               o_vld,
    output logic [alc_pkg::LUX_W-1:0]          o_lux,
    output logic [alc_pkg::BAND_W-1:0]         o_band
);
    import alc_pkg::*;

    localparam int PROD_W = ACC_W + ENTRY_W;

    logic [PROD_W-1:0]  w_prod;
    logic [ACC_W-1:0]   n_t1;
    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]   w_sh;
    logic [LUX_W-1:0]   n_lux;

    logic               r_a_vld;
    logic [BAND_W-1:0]  r_a_band;
    logic [ACC_W-1:0]   r_t0;
    logic [ACC_W-1:0]   r_t1;
    logic               r_vld;
    logic [BAND_W-1:0]  r_band;
    logic [LUX_W-1:0]   r_lux;

    // In the lowest band the infrared term carries the Q0.16 power factor.
    assign w_prod = PROD_W'(i_side.kc1) * PROD_W'(i_entry);
    assign n_t1   = (i_side.band == BAND_LOW) ? w_prod[PROD_W-1:ENTRY_W] : i_side.kc1;

    assign n_acc  = (r_t1 > r_t0) ? '0 : (r_t0 - r_t1);
    assign w_sh   = n_acc >> LUX_SHIFT;
    assign n_lux  = (|w_sh[ACC_W-1:LUX_W]) ? '1 : w_sh[LUX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_vld   <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_band <= i_side.band;
            r_t0     <= i_side.t0;
            r_t1     <= n_t1;
            r_band   <= r_a_band;
            r_lux    <= n_lux;
        end
    end

    assign o_vld  = r_vld;
    assign o_lux  = r_lux;
    assign o_band = r_band;

    a_dark_bands_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_band == BAND_ZERO || r_band == BAND_OVER)) |-> (r_lux == '0))
        else $error("nonzero lux for zero channel or ratio above range");

endmodule

`default_nettype wire

// File: src/ambient_light_lux_calc_top.sv
// Two-channel ambient light lux calculator, top level.
// Instantiates alc_div_stage, alc_pow_lut and alc_mix; depends on alc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per reading pair:
//   i_channel0 (visible plus infrared) and i_channel1 (infrared), raw counts.
//   Output channel (o_out_valid / i_out_ready) returns one beat per input beat
//   with o_lux_q16 (unsigned, LUX_FRAC_BITS fraction bits) and o_band.
//   The band compare, coefficient multiply, four divider stages (four quotient
//   bits each), index scaling, table read, infrared scaling and the final
//   subtract each own one register stage, ending in the output register.
//   Throughput is one beat per cycle while the output is not stalled, so a
//   new pair can enter every cycle.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   o_in_ready drops in the same cycle; nothing is lost or repeated, and bubbles
//   behind a held result are not squeezed out.
//   Synchronous active-low reset clears all valid bits; data registers are
//   not reset, and the block needs no setup after reset.
`default_nettype none

module ambient_light_lux_calc_top #(
    parameter int POWER_TABLE_ENTRIES = alc_pkg::POWER_TABLE_ENTRIES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [alc_pkg::CH_W-1:0]     i_channel0,
    input  wire logic [alc_pkg::CH_W-1:0]     i_channel1,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [alc_pkg::LUX_W-1:0]         o_lux_q16,
    output logic [alc_pkg::BAND_W-1:0]        o_band
);
    import alc_pkg::*;

    localparam int CMP_W = CH_W + 8;

    logic                w_en;
    logic [BAND_W-1:0]   n_band;
    logic [COEF_W-1:0]   n_kvis;
    logic [COEF_W-1:0]   n_kir;
    t_side               n_side;
    t_div                n_div;

    logic                r_s1_vld;
    logic [CH_W-1:0]     r_s1_c0;
    logic [CH_W-1:0]     r_s1_c1;
    logic [BAND_W-1:0]   r_s1_band;
    logic                r_s2_vld;
    t_side               r_s2_side;
    t_div                r_s2_div;

    logic                w_dv_vld  [DIV_STAGES+1];
    t_side               w_dv_side [DIV_STAGES+1];
    t_div                w_dv_div  [DIV_STAGES+1];

    logic                w_lut_vld;
    t_side               w_lut_side;
    logic [ENTRY_W-1:0]  w_lut_entry;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Ratio bands by cross-multiplication, exact for every count pair.
    always_comb begin
        logic [CMP_W-1:0] v_c0;
        logic [CMP_W-1:0] v_c1;
        v_c0 = CMP_W'(i_channel0);
        v_c1 = CMP_W'(i_channel1);
        if (i_channel0 == '0) begin
            n_band = BAND_ZERO;
        end else if (CMP_W'(2) * v_c1 <= v_c0) begin
            n_band = BAND_LOW;
        end else if (CMP_W'(100) * v_c1 <= CMP_W'(61) * v_c0) begin
            n_band = BAND_MID;
        end else if (CMP_W'(5) * v_c1 <= CMP_W'(4) * v_c0) begin
            n_band = BAND_HIGH;
        end else if (CMP_W'(10) * v_c1 <= CMP_W'(13) * v_c0) begin
            n_band = BAND_TOP;
        end else begin
            n_band = BAND_OVER;
        end
    end

    always_comb begin
        case (r_s1_band)
            BAND_LOW: begin
                n_kvis = K_B1_VIS;
                n_kir  = K_B1_IR;
            end
            BAND_MID: begin
                n_kvis = K_B2_VIS;
                n_kir  = K_B2_IR;
            end
            BAND_HIGH: begin
                n_kvis = K_B3_VIS;
                n_kir  = K_B3_IR;
            end
            BAND_TOP: begin
                n_kvis = K_B4_VIS;
                n_kir  = K_B4_IR;
            end
            default: begin
                n_kvis = '0;
                n_kir  = '0;
            end
        endcase
    end

    // Only the lowest band needs the ratio; other bands feed the divider a zero dividend.
    assign n_side.band = r_s1_band;
    assign n_side.t0   = ACC_W'(n_kvis) * ACC_W'(r_s1_c0);
    assign n_side.kc1  = ACC_W'(n_kir) * ACC_W'(r_s1_c1);
    assign n_div.c0    = r_s1_c0;
    assign n_div.rem   = (r_s1_band == BAND_LOW) ? r_s1_c1 : '0;
    assign n_div.quo   = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_c0   <= i_channel0;
            r_s1_c1   <= i_channel1;
            r_s1_band <= n_band;
            r_s2_side <= n_side;
            r_s2_div  <= n_div;
        end
    end

    assign w_dv_vld[0]  = r_s2_vld;
    assign w_dv_side[0] = r_s2_side;
    assign w_dv_div[0]  = r_s2_div;

    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_div
        alc_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dv_vld[gs]),
            .i_side  (w_dv_side[gs]),
            .i_div   (w_dv_div[gs]),
            .o_vld   (w_dv_vld[gs+1]),
            .o_side  (w_dv_side[gs+1]),
            .o_div   (w_dv_div[gs+1])
        );
    end

    alc_pow_lut #(
        .ENTRIES (POWER_TABLE_ENTRIES)
    ) u_pow_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dv_vld[DIV_STAGES]),
        .i_side  (w_dv_side[DIV_STAGES]),
        .i_quo   (w_dv_div[DIV_STAGES].quo),
        .o_vld   (w_lut_vld),
        .o_side  (w_lut_side),
        .o_entry (w_lut_entry)
    );

    alc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_lut_vld),
        .i_side  (w_lut_side),
        .i_entry (w_lut_entry),
        .o_vld   (o_out_valid),
        .o_lux   (o_lux_q16),
        .o_band  (o_band)
    );

    a_stall_reaches_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output is stalled");

    a_band_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_band <= BAND_OVER))
        else $error("band code out of range");

    a_stall_holds_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_s1_vld))
        else $error("front stage moved during a stall");

endmodule

`default_nettype wire
